// ----- src/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the setpoint ramp tracker
// Sequencer states, job codes, fixed-point constants and datapath widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  // datapath widths of the shared divider and root units
  localparam int DIV_DW = 64;
  localparam int DIV_VW = 34;
  localparam int SQ_W   = 64;
  localparam int SQ_RW  = 32;

  // Q16.16 angle constants
  localparam int PI_Q     = 205887;
  localparam int TWO_PI_Q = 411775;

  localparam int DT_DEFAULT_US = 10000;
  localparam int DT_MIN_US     = 1000;
  localparam int US_PER_S      = 1000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MUL_WB,
    ST_DIV,
    ST_SQRT,
    ST_APPLY,
    ST_WRAP_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    JOB_SH,
    JOB_SA,
    JOB_SD,
    JOB_ST,
    JOB_SQX,
    JOB_SQY,
    JOB_PX,
    JOB_PY
  } job_e;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_GOAL,
    KIND_ACTIVATE,
    KIND_DEACTIVATE
  } kind_e;

  typedef enum logic [1:0] {
    CFG_HSPD,
    CFG_ASPD,
    CFG_DSPD,
    CFG_TSPD
  } cfg_e;

  // wrap an angle within one turn of the principal range back to +-pi
  function automatic logic signed [18:0] wrap_small(input logic signed [20:0] v);
    logic signed [20:0] r;
    r = v + 21'(PI_Q);
    if (r < 0) begin
      r = r + 21'(TWO_PI_Q);
    end else if (r >= 21'(TWO_PI_Q)) begin
      r = r - 21'(TWO_PI_Q);
    end
    r = r - 21'(PI_Q);
    return r[18:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/setpoint_ramp_tracker.sv -----
// ----------------------------------------------------------------------------
// setpoint_ramp_tracker: constant-rate setpoint ramp
// Steps a commanded position and heading toward a goal on each odometry tick.
//
//   channel  signals                               direction
//   in       in_valid_i / in_stall_o, kind..yaw    item in
//   out      out_valid_o / out_stall_i, cmd_*      command out
//   cfg      cfg_we_i, cfg_idx_i, cfg_data_i       register write
//
// Goal, activate, deactivate and idle ticks are taken in the idle state. A
// running tick goes up to the output register through seven passes of the
// shared divider (four step lengths, two horizontal components, one heading
// wrap), each multiply-fed pass set up in ST_MUL and ST_MUL_WB, and one root
// pass, fed by a single registered 32x32 multiplier.
// in_stall_o is high while a tick is being worked; the result waits in an
// output register so a new item can be taken while out_stall_i holds it.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module setpoint_ramp_tracker
  import srt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [30:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [47:0]        stamp_us_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  input  wire logic signed [18:0] yaw_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      cmd_x_o,
  output logic signed [31:0]      cmd_y_o,
  output logic signed [31:0]      cmd_z_o,
  output logic signed [18:0]      cmd_yaw_o
);

  localparam logic [31:0] CAP32 = 32'hFFFF_FFFF;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  state_e state_q, state_d;
  job_e   job_q, job_d;

  logic        running_q, running_d;
  logic        first_q, first_d;
  logic [47:0] prev_q, prev_d;
  logic [30:0] hspd_q, hspd_d, aspd_q, aspd_d, dspd_q, dspd_d, tspd_q, tspd_d;

  logic signed [31:0] now_x_q, now_x_d, now_y_q, now_y_d, now_z_q, now_z_d;
  logic signed [31:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d, goal_z_q, goal_z_d;
  logic signed [18:0] now_yaw_q, now_yaw_d, goal_yaw_q, goal_yaw_d;

  logic        neg_q, neg_d;
  logic [31:0] dtmag_q, dtmag_d;
  logic [43:0] sh_q, sh_d, sa_q, sa_d, sd_q, sd_d, st_q, st_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] sumsq_q, sumsq_d;
  logic [32:0] n_q, n_d;
  logic [33:0] px_q, px_d, py_q, py_d;
  logic        yneg_q, yneg_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] cmd_x_q, cmd_x_d, cmd_y_q, cmd_y_d, cmd_z_q, cmd_z_d;
  logic signed [18:0] cmd_yaw_q, cmd_yaw_d;

  // shared units
  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_dividend, div_quot;
  logic [DIV_VW-1:0] div_divisor, div_rem;
  logic              sq_start, sq_done;
  logic [SQ_W-1:0]   sq_val;
  logic [SQ_RW-1:0]  sq_root;

  logic [31:0] mul_a, mul_b;

  // tick time step
  logic        in_acc;
  logic [47:0] dt;
  logic [47:0] dt_mag;

  // horizontal terms
  logic signed [32:0] dx, dy;
  logic [32:0]        ax_w, ay_w;
  logic [31:0]        ax, ay, hx, hy, smag;
  logic               big;
  logic signed [34:0] px_s, py_s;
  logic signed [44:0] sh_s, sa_s, sd_s, st_s;
  logic               snap_h;

  // vertical terms
  logic signed [32:0] dz;
  logic signed [44:0] dz45;
  logic [31:0]        capa, capd, zmag;
  logic signed [33:0] step_z;
  logic               snap_z;

  // heading terms
  logic signed [18:0] d, dabs;
  logic signed [45:0] yaw_mv, yaw_pre;
  logic signed [46:0] yv;
  logic [46:0]        yabs;
  logic               snap_y;
  logic [18:0]        wr, wrr;
  logic signed [19:0] yfin;

  srt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  srt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // datapath terms
  always_comb begin
    dt = first_q ? 48'(DT_DEFAULT_US) : stamp_us_i - prev_q;
    if ($signed(dt) > -48'sd1000 && $signed(dt) < 48'sd1000) begin
      dt = 48'(DT_DEFAULT_US);
    end
    dt_mag = dt[47] ? -dt : dt;

    dx   = {goal_x_q[31], goal_x_q} - {now_x_q[31], now_x_q};
    dy   = {goal_y_q[31], goal_y_q} - {now_y_q[31], now_y_q};
    ax_w = dx[32] ? -dx : dx;
    ay_w = dy[32] ? -dy : dy;
    ax   = ax_w[31:0];
    ay   = ay_w[31:0];
    big  = ax[31] | ay[31];
    hx   = big ? {1'b0, ax[31:1]} : ax;
    hy   = big ? {1'b0, ay[31:1]} : ay;
    smag = (sh_q > {12'd0, CAP32}) ? CAP32 : sh_q[31:0];

    sh_s = neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});
    sa_s = neg_q ? -$signed({1'b0, sa_q}) : $signed({1'b0, sa_q});
    sd_s = neg_q ? -$signed({1'b0, sd_q}) : $signed({1'b0, sd_q});
    st_s = neg_q ? -$signed({1'b0, st_q}) : $signed({1'b0, st_q});

    px_s   = (dx[32] != neg_q) ? -$signed({1'b0, px_q}) : $signed({1'b0, px_q});
    py_s   = (dy[32] != neg_q) ? -$signed({1'b0, py_q}) : $signed({1'b0, py_q});
    snap_h = $signed({12'd0, n_q}) <= sh_s;

    dz     = {goal_z_q[31], goal_z_q} - {now_z_q[31], now_z_q};
    dz45   = {{12{dz[32]}}, dz};
    capa   = (sa_q > {12'd0, CAP32}) ? CAP32 : sa_q[31:0];
    capd   = (sd_q > {12'd0, CAP32}) ? CAP32 : sd_q[31:0];
    zmag   = dz[32] ? capd : capa;
    step_z = (dz[32] ^ neg_q) ? -$signed({2'b0, zmag}) : $signed({2'b0, zmag});
    snap_z = (!dz[32] && dz != 33'sd0 && dz45 <= sa_s) || (dz[32] && -dz45 <= sd_s);

    d    = wrap_small({{2{goal_yaw_q[18]}}, goal_yaw_q} - {{2{now_yaw_q[18]}}, now_yaw_q});
    dabs = d[18] ? -d : d;
    if (!d[18] && d != 19'sd0) begin
      yaw_mv = {{27{now_yaw_q[18]}}, now_yaw_q} + {st_s[44], st_s};
    end else if (d[18]) begin
      yaw_mv = {{27{now_yaw_q[18]}}, now_yaw_q} - {st_s[44], st_s};
    end else begin
      yaw_mv = {{27{now_yaw_q[18]}}, now_yaw_q};
    end
    snap_y  = $signed({26'd0, dabs}) <= st_s;
    yaw_pre = snap_y ? {{27{goal_yaw_q[18]}}, goal_yaw_q} : yaw_mv;
    yv      = {yaw_pre[45], yaw_pre} + 47'(PI_Q);
    yabs    = yv[46] ? -yv : yv;

    wr   = div_rem[18:0];
    wrr  = (yneg_q && wr != 19'd0) ? 19'(TWO_PI_Q) - wr : wr;
    yfin = $signed({1'b0, wrr}) - 20'(PI_Q);
  end

  // shared multiplier operands
  always_comb begin
    case (job_q)
      JOB_SH: begin
        mul_a = {1'b0, hspd_q};
        mul_b = dtmag_q;
      end
      JOB_SA: begin
        mul_a = {1'b0, aspd_q};
        mul_b = dtmag_q;
      end
      JOB_SD: begin
        mul_a = {1'b0, dspd_q};
        mul_b = dtmag_q;
      end
      JOB_ST: begin
        mul_a = {1'b0, tspd_q};
        mul_b = dtmag_q;
      end
      JOB_SQX: begin
        mul_a = hx;
        mul_b = hx;
      end
      JOB_SQY: begin
        mul_a = hy;
        mul_b = hy;
      end
      JOB_PX: begin
        mul_a = smag;
        mul_b = ax;
      end
      JOB_PY: begin
        mul_a = smag;
        mul_b = ay;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    running_d  = running_q;
    first_d    = first_q;
    prev_d     = prev_q;
    hspd_d     = hspd_q;
    aspd_d     = aspd_q;
    dspd_d     = dspd_q;
    tspd_d     = tspd_q;
    now_x_d    = now_x_q;
    now_y_d    = now_y_q;
    now_z_d    = now_z_q;
    now_yaw_d  = now_yaw_q;
    goal_x_d   = goal_x_q;
    goal_y_d   = goal_y_q;
    goal_z_d   = goal_z_q;
    goal_yaw_d = goal_yaw_q;
    neg_d      = neg_q;
    dtmag_d    = dtmag_q;
    sh_d       = sh_q;
    sa_d       = sa_q;
    sd_d       = sd_q;
    st_d       = st_q;
    sumsq_d    = sumsq_q;
    n_d        = n_q;
    px_d       = px_q;
    py_d       = py_q;
    yneg_d     = yneg_q;
    cmd_x_d    = cmd_x_q;
    cmd_y_d    = cmd_y_q;
    cmd_z_d    = cmd_z_q;
    cmd_yaw_d  = cmd_yaw_q;

    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = DIV_VW'(US_PER_S);
    sq_start     = 1'b0;
    sq_val       = sumsq_q + prod_q;

    // drain the output register
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_HSPD: hspd_d = cfg_data_i;
        CFG_ASPD: aspd_d = cfg_data_i;
        CFG_DSPD: dspd_d = cfg_data_i;
        CFG_TSPD: tspd_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind_e'(kind_i))
            KIND_GOAL: begin
              goal_x_d   = coord_x_i;
              goal_y_d   = coord_y_i;
              goal_z_d   = coord_z_i;
              goal_yaw_d = wrap_small({{2{yaw_in_i[18]}}, yaw_in_i});
            end
            KIND_ACTIVATE: begin
              goal_x_d   = coord_x_i;
              goal_y_d   = coord_y_i;
              goal_z_d   = coord_z_i;
              goal_yaw_d = wrap_small({{2{yaw_in_i[18]}}, yaw_in_i});
              now_x_d    = coord_x_i;
              now_y_d    = coord_y_i;
              now_z_d    = coord_z_i;
              now_yaw_d  = wrap_small({{2{yaw_in_i[18]}}, yaw_in_i});
              running_d  = 1'b1;
            end
            KIND_DEACTIVATE: begin
              running_d = 1'b0;
            end
            default: begin
              first_d = 1'b0;
              prev_d  = stamp_us_i;
              neg_d   = dt[47];
              dtmag_d = (dt_mag[47:32] != 16'd0) ? CAP32 : dt_mag[31:0];
              if (running_q) begin
                job_d   = JOB_SH;
                state_d = ST_MUL;
              end
            end
          endcase
        end
      end
      ST_MUL: begin
        state_d = ST_MUL_WB;
      end
      ST_MUL_WB: begin
        case (job_q)
          JOB_SQX: begin
            sumsq_d = prod_q;
            job_d   = JOB_SQY;
            state_d = ST_MUL;
          end
          JOB_SQY: begin
            sq_start = 1'b1;
            state_d  = ST_SQRT;
          end
          JOB_PX, JOB_PY: begin
            div_divisor = {1'b0, n_q};
            div_start   = 1'b1;
            state_d     = ST_DIV;
          end
          default: begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          job_d   = job_e'(job_q + 3'd1);
          state_d = ST_MUL;
          case (job_q)
            JOB_SH: sh_d = div_quot[43:0];
            JOB_SA: sa_d = div_quot[43:0];
            JOB_SD: sd_d = div_quot[43:0];
            JOB_ST: st_d = div_quot[43:0];
            JOB_PX: px_d = div_quot[33:0];
            JOB_PY: begin
              py_d    = div_quot[33:0];
              state_d = ST_APPLY;
            end
            default: ;
          endcase
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          n_d = big ? {sq_root, 1'b0} : {1'b0, sq_root};
          if (sq_root == '0) begin
            px_d    = '0;
            py_d    = '0;
            state_d = ST_APPLY;
          end else begin
            job_d   = JOB_PX;
            state_d = ST_MUL;
          end
        end
      end
      ST_APPLY: begin
        // zero components leave the position unchanged when the distance is zero
        now_x_d = sat32({{4{now_x_q[31]}}, now_x_q} + {px_s[34], px_s});
        now_y_d = sat32({{4{now_y_q[31]}}, now_y_q} + {py_s[34], py_s});
        if (snap_h) begin
          now_x_d = goal_x_q;
          now_y_d = goal_y_q;
        end
        now_z_d = snap_z ? goal_z_q
                         : sat32({{4{now_z_q[31]}}, now_z_q} + {{2{step_z[33]}}, step_z});
        yneg_d       = yv[46];
        div_dividend = {17'd0, yabs};
        div_divisor  = DIV_VW'(TWO_PI_Q);
        div_start    = 1'b1;
        state_d      = ST_WRAP_DIV;
      end
      ST_WRAP_DIV: begin
        if (div_done) begin
          now_yaw_d = yfin[18:0];
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_x_d     = now_x_q;
          cmd_y_d     = now_y_q;
          cmd_z_d     = now_z_q;
          cmd_yaw_d   = now_yaw_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_SH;
      running_q   <= 1'b0;
      first_q     <= 1'b1;
      prev_q      <= '0;
      hspd_q      <= 31'd65536;
      aspd_q      <= 31'd65536;
      dspd_q      <= 31'd65536;
      tspd_q      <= 31'd65536;
      now_x_q     <= '0;
      now_y_q     <= '0;
      now_z_q     <= '0;
      now_yaw_q   <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      goal_z_q    <= '0;
      goal_yaw_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      running_q   <= running_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      hspd_q      <= hspd_d;
      aspd_q      <= aspd_d;
      dspd_q      <= dspd_d;
      tspd_q      <= tspd_d;
      now_x_q     <= now_x_d;
      now_y_q     <= now_y_d;
      now_z_q     <= now_z_d;
      now_yaw_q   <= now_yaw_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      goal_z_q    <= goal_z_d;
      goal_yaw_q  <= goal_yaw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q     <= neg_d;
    dtmag_q   <= dtmag_d;
    sh_q      <= sh_d;
    sa_q      <= sa_d;
    sd_q      <= sd_d;
    st_q      <= st_d;
    prod_q    <= prod_d;
    sumsq_q   <= sumsq_d;
    n_q       <= n_d;
    px_q      <= px_d;
    py_q      <= py_d;
    yneg_q    <= yneg_d;
    cmd_x_q   <= cmd_x_d;
    cmd_y_q   <= cmd_y_d;
    cmd_z_q   <= cmd_z_d;
    cmd_yaw_q <= cmd_yaw_d;
  end

  assign out_valid_o = out_valid_q;
  assign cmd_x_o     = cmd_x_q;
  assign cmd_y_o     = cmd_y_q;
  assign cmd_z_o     = cmd_z_q;
  assign cmd_yaw_o   = cmd_yaw_q;

endmodule

`default_nettype wire

// ----- src/srt_div.sv -----
// ----------------------------------------------------------------------------
// srt_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, quotient and remainder out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srt_div
  import srt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_DW-1:0] dividend_i,
  input  wire logic [DIV_VW-1:0] divisor_i,
  output logic                   done_o,
  output logic [DIV_DW-1:0]      quot_o,
  output logic [DIV_VW-1:0]      rem_o
);

  localparam int CW = $clog2(DIV_DW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_DW-1:0] quot_q, quot_d;
  logic [DIV_VW-1:0] rem_q, rem_d;
  logic [DIV_VW-1:0] dsr_q, dsr_d;
  logic [DIV_VW:0]   rem_sh;
  logic [DIV_VW:0]   rem_nx;
  logic              ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q, quot_q[DIV_DW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIV_DW);
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[DIV_DW-2:0], ge};
      rem_d  = rem_nx[DIV_VW-1:0];
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- src/srt_sqrt.sv -----
// ----------------------------------------------------------------------------
// srt_sqrt: iterative integer square root
// Digit-by-digit root, two radicand bits per cycle, floor of the root out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srt_sqrt
  import srt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SQ_W-1:0] val_i,
  output logic                 done_o,
  output logic [SQ_RW-1:0]     root_o
);

  localparam int CW = $clog2(SQ_W / 2 + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [SQ_W-1:0] x_q, x_d;
  logic [SQ_W-1:0] r_q, r_d;
  logic [SQ_W-1:0] bit_q, bit_d;
  logic [SQ_W-1:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    trial  = r_q + bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(SQ_W / 2);
      x_d    = val_i;
      r_d    = '0;
      bit_d  = {2'b01, {(SQ_W - 2){1'b0}}};
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d = x_q - trial;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[SQ_RW-1:0];

endmodule

`default_nettype wire

// ----- dv/setpoint_ramp_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// setpoint_ramp_tracker_tb: self-checking testbench of the setpoint ramp
// Drives goal, activate, deactivate and odometry-tick transactions, predicts
// each command with a fixed-point ramp model kept in the bench and compares
// every command field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module setpoint_ramp_tracker_tb;
  import srt_pkg::*;

  localparam longint STEP_CAP   = 64'h0000_0000_FFFF_FFFF;
  localparam int     IDLE_LIMIT = 20000;
  localparam int     SETTLE     = 20;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [18:0] yaw;
  } cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [30:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i = '0;
  logic [47:0]        stamp_us_i = '0;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic signed [18:0] yaw_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] cmd_x_o;
  logic signed [31:0] cmd_y_o;
  logic signed [31:0] cmd_z_o;
  logic signed [18:0] cmd_yaw_o;

  setpoint_ramp_tracker dut (.*);

  always #5 clk_i = ~clk_i;

  // ramp state held by the bench
  logic [30:0] spd_h, spd_a, spd_d, spd_t;
  longint      trk_x, trk_y, trk_z, trk_yaw;
  longint      aim_x, aim_y, aim_z, aim_yaw;
  logic [47:0] last_stamp;
  bit          fresh, engaged;

  cmd_t   pending_cmds[$];
  int     err_count, items_sent, cmds_checked, idle_cycles;
  bit     quiet;
  logic [47:0] clock_us;

  function automatic longint wrap_ang(input longint v);
    longint r;
    r = (v + PI_Q) % TWO_PI_Q;
    if (r < 0) r += TWO_PI_Q;
    return r - PI_Q;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint step_len(input logic [30:0] spd, input longint unsigned mag,
                                      input bit neg);
    longint unsigned p;
    longint m;
    p = spd;
    m = longint'((p * mag) / 64'd1000000);
    return neg ? -m : m;
  endfunction

  function automatic longint clamp_step(input longint s);
    if (s > STEP_CAP) return STEP_CAP;
    if (s < -STEP_CAP) return -STEP_CAP;
    return s;
  endfunction

  // advance the ramp by one transaction; returns 1 when a command is due
  function automatic bit advance_ramp(input kind_e k, input logic [47:0] st,
                                      input longint cx, cy, cz, cyaw, output cmd_t c);
    longint dt, sh, sa, sd, sturn, dx, dy, dz, d, shc, px, py;
    longint unsigned mag, ax, ay, n, smag;
    logic [47:0] dd;
    bit neg;
    c = '0;
    case (k)
      KIND_GOAL: begin
        aim_x = cx; aim_y = cy; aim_z = cz; aim_yaw = wrap_ang(cyaw);
        return 0;
      end
      KIND_ACTIVATE: begin
        trk_x = cx; trk_y = cy; trk_z = cz; trk_yaw = wrap_ang(cyaw);
        aim_x = cx; aim_y = cy; aim_z = cz; aim_yaw = trk_yaw;
        engaged = 1;
        return 0;
      end
      KIND_DEACTIVATE: begin
        engaged = 0;
        return 0;
      end
      default: ;
    endcase
    if (fresh) begin
      dt = DT_DEFAULT_US;
      fresh = 0;
    end else begin
      dd = st - last_stamp;
      dt = {{16{dd[47]}}, dd};
    end
    last_stamp = st;
    if (dt > -DT_MIN_US && dt < DT_MIN_US) dt = DT_DEFAULT_US;
    if (!engaged) return 0;

    neg = dt < 0;
    mag = neg ? -dt : dt;
    if (mag > STEP_CAP) mag = STEP_CAP;
    sh = step_len(spd_h, mag, neg);
    sa = step_len(spd_a, mag, neg);
    sd = step_len(spd_d, mag, neg);
    sturn = step_len(spd_t, mag, neg);

    // move along the unit vector to the goal, halving huge distances
    dx = aim_x - trk_x;
    dy = aim_y - trk_y;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
      n = int_sqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1)) << 1;
    else
      n = int_sqrt(ax * ax + ay * ay);
    shc = clamp_step(sh);
    smag = shc < 0 ? -shc : shc;
    if (n != 0) begin
      px = longint'(smag * ax / n);
      py = longint'(smag * ay / n);
      if ((dx < 0) != neg) px = -px;
      if ((dy < 0) != neg) py = -py;
      trk_x = sat32(trk_x + px);
      trk_y = sat32(trk_y + py);
    end
    if (longint'(n) <= sh) begin
      trk_x = aim_x;
      trk_y = aim_y;
    end

    dz = aim_z - trk_z;
    trk_z = sat32(trk_z + (dz >= 0 ? clamp_step(sa) : -clamp_step(sd)));
    if ((dz > 0 && dz <= sa) || (dz < 0 && -dz <= sd)) trk_z = aim_z;

    d = wrap_ang(aim_yaw - trk_yaw);
    if (d > 0) trk_yaw += sturn;
    else if (d < 0) trk_yaw -= sturn;
    if ((d < 0 ? -d : d) <= sturn) trk_yaw = aim_yaw;
    trk_yaw = wrap_ang(trk_yaw);

    c.x = trk_x[31:0];
    c.y = trk_y[31:0];
    c.z = trk_z[31:0];
    c.yaw = trk_yaw[18:0];
    return 1;
  endfunction

  // one transaction on the input channel
  task automatic send_item(input kind_e k, input logic [47:0] st,
                           input logic signed [31:0] x, y, z, input logic signed [18:0] yw);
    cmd_t c;
    if (!quiet && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    stamp_us_i <= st;
    coord_x_i  <= x;
    coord_y_i  <= y;
    coord_z_i  <= z;
    yaw_in_i   <= yw;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (advance_ramp(k, st, x, y, z, yw, c)) pending_cmds.push_back(c);
  endtask

  task automatic send_tick(input logic [47:0] step_us);
    clock_us += step_us;
    send_item(KIND_TICK, clock_us, $urandom, $urandom, $urandom, 19'($urandom));
  endtask

  // hold the input until every command is back, then let the block settle
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [30:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_HSPD: spd_h = val;
      CFG_ASPD: spd_a = val;
      CFG_DSPD: spd_d = val;
      default:  spd_t = val;
    endcase
  endtask

  task automatic write_speeds(input logic [30:0] h, a, d, t);
    write_reg(CFG_HSPD, h);
    write_reg(CFG_ASPD, a);
    write_reg(CFG_DSPD, d);
    write_reg(CFG_TSPD, t);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord;
    if ($urandom_range(99) < 15) return $urandom;
    return $signed($urandom_range(2621440)) - 32'sd1310720;
  endfunction

  function automatic logic signed [18:0] rand_yaw;
    if ($urandom_range(99) < 15) return 19'($urandom);
    return 19'($signed($urandom_range(2 * PI_Q)) - PI_Q);
  endfunction

  function automatic logic [30:0] rand_speed;
    case ($urandom_range(9))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2, 3:    return 31'($urandom);
      default: return 31'($urandom_range(1 << 20));
    endcase
  endfunction

  // output side: random stall and the command check
  always @(posedge clk_i) begin
    cmd_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: command with none expected: x=%0d y=%0d z=%0d yaw=%0d",
                 $time, cmd_x_o, cmd_y_o, cmd_z_o, cmd_yaw_o);
        err_count++;
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked++;
        if (cmd_x_o !== want.x) begin
          $display("%0t: cmd_x expected %0d actual %0d", $time, want.x, cmd_x_o);
          err_count++;
        end
        if (cmd_y_o !== want.y) begin
          $display("%0t: cmd_y expected %0d actual %0d", $time, want.y, cmd_y_o);
          err_count++;
        end
        if (cmd_z_o !== want.z) begin
          $display("%0t: cmd_z expected %0d actual %0d", $time, want.z, cmd_z_o);
          err_count++;
        end
        if (cmd_yaw_o !== want.yaw) begin
          $display("%0t: cmd_yaw expected %0d actual %0d", $time, want.yaw, cmd_yaw_o);
          err_count++;
        end
      end
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 19);
  end

  // end the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("[setpoint_ramp_tracker] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ticks before activation, goal while idle, odd stamps and odd yaw
  task automatic test_directed;
    write_speeds(31'd65536, 31'd65536, 31'd65536, 31'd65536);
    clock_us = 48'd5_000_000;
    send_tick(0);
    send_item(KIND_GOAL, '0, 32'sd196608, -32'sd131072, 32'sd98304, 19'sd65536);
    send_item(KIND_ACTIVATE, '0, 32'sd0, 32'sd0, 32'sd0, 19'sd0);
    send_item(KIND_GOAL, '0, 32'sd196608, -32'sd131072, 32'sd98304, 19'sd65536);
    send_tick(10000);
    send_tick(500);
    send_tick(250000);
    send_tick(48'hFFFF_FFFF_EC78);
    send_tick(48'h0100_0000_0000);
    send_tick(2_000_000);
    send_item(KIND_ACTIVATE, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 19'sd205887);
    send_item(KIND_GOAL, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -19'sd205887);
    send_tick(10000);
    send_tick(48'h0000_FFFF_FFFF);
    send_item(KIND_GOAL, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -19'sd262144);
    send_tick(48'hFFFF_0000_0000);
    send_item(KIND_ACTIVATE, '0, 32'sd0, 32'sd0, 32'sd0, 19'sd262143);
    send_item(KIND_GOAL, '0, 32'sd0, 32'sd0, 32'sd0, -19'sd262144);
    send_tick(20000);
    send_item(KIND_DEACTIVATE, '0, 32'sd0, 32'sd0, 32'sd0, 19'sd0);
    send_tick(20000);
    send_item(KIND_GOAL, 48'hFFFF_FFFF_FFFF, -32'sd1, -32'sd1, -32'sd1, -19'sd1);
    send_item(KIND_ACTIVATE, 48'hFFFF_FFFF_FFFF, 32'sd65536, 32'sd0, -32'sd65536, 19'sd0);
    send_tick(30000);
    drain();
  endtask

  // one activated approach toward a random goal
  task automatic run_approach(input int ticks);
    send_item(KIND_ACTIVATE, 48'($urandom), rand_coord(), rand_coord(), rand_coord(),
              rand_yaw());
    send_item(KIND_GOAL, 48'($urandom), rand_coord(), rand_coord(), rand_coord(), rand_yaw());
    repeat (ticks) begin
      case ($urandom_range(99))
        0, 1, 2, 3:  send_tick($urandom_range(999));
        4, 5, 6, 7:  send_tick(-$urandom_range(200000, 1000));
        8, 9:        begin
          clock_us = {16'($urandom), 32'($urandom)};
          send_tick(0);
        end
        10, 11, 12:  send_item(KIND_GOAL, {16'($urandom), 32'($urandom)}, rand_coord(),
                               rand_coord(), rand_coord(), rand_yaw());
        13, 14:      send_item(kind_e'($urandom_range(3)), {16'($urandom), 32'($urandom)},
                               $urandom, $urandom, $urandom, 19'($urandom));
        default:     send_tick($urandom_range(50000, 1000));
      endcase
    end
    if ($urandom_range(3) == 0)
      send_item(KIND_DEACTIVATE, '0, $urandom, $urandom, $urandom, 19'($urandom));
  endtask

  // corner speed settings, zero and full scale
  task automatic test_speed_extremes;
    logic [30:0] sets [4][4];
    sets = '{'{31'd0, 31'd0, 31'd0, 31'd0},
             '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF},
             '{31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'd0},
             '{31'd1, 31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF}};
    foreach (sets[i]) begin
      write_speeds(sets[i][0], sets[i][1], sets[i][2], sets[i][3]);
      run_approach(10);
      drain();
    end
  endtask

  // random phases; one stretch runs with no idling on either side
  task automatic test_random;
    int phase;
    phase = 0;
    while (items_sent < 1160) begin
      write_speeds(rand_speed(), rand_speed(), rand_speed(), rand_speed());
      quiet = (phase == 3);
      repeat ($urandom_range(5, 2)) run_approach($urandom_range(14, 3));
      drain();
      quiet = 0;
      phase++;
    end
  endtask

  initial begin
    spd_h = 31'd65536; spd_a = 31'd65536; spd_d = 31'd65536; spd_t = 31'd65536;
    trk_x = 0; trk_y = 0; trk_z = 0; trk_yaw = 0;
    aim_x = 0; aim_y = 0; aim_z = 0; aim_yaw = 0;
    last_stamp = '0;
    fresh = 1;
    engaged = 0;
    quiet = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_speed_extremes();
    test_random();
    drain();
    $display("Sent %0d transactions and checked %0d commands over zero, full-scale",
             items_sent, cmds_checked);
    $display("and random speeds, with odd stamps, huge distances and wrapped headings.");
    if (err_count == 0) begin
      $display("[setpoint_ramp_tracker] OK");
    end else begin
      $display("[setpoint_ramp_tracker] ERROR");
    end
    $finish;
  end

endmodule
